/* hw/rtl/vsa_pkg.sv */
package vsa_pkg;

  localparam int VOICE_SLOTS_DEF = 32;

  localparam int KIND_W = 2;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int SLOT_W = 5;
  localparam int MASK_W = 32;

  localparam logic [KIND_W-1:0] KIND_ON   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

  // slot entry: busy, releasing, note
  typedef struct packed {
    logic              busy;
    logic              rel;
    logic [NOTE_W-1:0] note;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

/* hw/rtl/vsa_ram.sv */
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/polyphonic_voice_slot_allocator_core.sv */
// channel   signals                                          timing
// request   start, busy, kind, note_number, note_velocity,   taken when start && !busy
//           done_slot
// result    strobe, started, start_slot, stolen,             one cycle, cannot be stalled
//           release_mask, start_note, start_velocity
//
// note events scan the slot memory one entry a cycle through its single read port,
// read-modify-write, then write the chosen slot.
// voice finished and unknown kinds skip the scan and never raise busy.
// reset clears per-slot valid flops at once, an invalid slot reads as free; no sweep.
// for note events busy is high from acceptance until the result strobe; the result is never held off.
module polyphonic_voice_slot_allocator_core #(
  parameter int VOICE_SLOTS = vsa_pkg::VOICE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [vsa_pkg::KIND_W-1:0]  kind,
  input  logic [vsa_pkg::NOTE_W-1:0]  note_number,
  input  logic [vsa_pkg::VEL_W-1:0]   note_velocity,
  input  logic [vsa_pkg::SLOT_W-1:0]  done_slot,
  output logic                        strobe,
  output logic                        started,
  output logic [vsa_pkg::SLOT_W-1:0]  start_slot,
  output logic                        stolen,
  output logic [vsa_pkg::MASK_W-1:0]  release_mask,
  output logic [vsa_pkg::NOTE_W-1:0]  start_note,
  output logic [vsa_pkg::VEL_W-1:0]   start_velocity
);

  localparam int IDX_W = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int CNT_W = $clog2(VOICE_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                   state;
  logic [VOICE_SLOTS-1:0]       valid;
  logic [CNT_W-1:0]             idx;
  logic                         rv;
  logic [IDX_W-1:0]             raddr_q;
  logic                         on_q;
  logic [vsa_pkg::NOTE_W-1:0]   note_q;
  logic [vsa_pkg::VEL_W-1:0]    vel_q;
  logic                         have_free;
  logic [IDX_W-1:0]             free_slot;
  logic                         have_rel;
  logic [IDX_W-1:0]             rel_slot;
  logic                         found_off;
  logic [vsa_pkg::MASK_W-1:0]   mask;

  logic                         rd_issue;
  logic [IDX_W-1:0]             rd_addr;
  logic [vsa_pkg::ENTRY_W-1:0]  rdata;
  vsa_pkg::slot_entry_t         ent;
  vsa_pkg::slot_entry_t         wentry;
  logic                         match;
  logic                         we;
  logic [IDX_W-1:0]             waddr;
  logic [IDX_W-1:0]             chosen;
  logic                         accept;
  logic                         note_on;
  logic                         note_release;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign note_on  = (kind == vsa_pkg::KIND_ON) && (note_velocity != '0);
  assign note_release = (kind == vsa_pkg::KIND_OFF) ||
                        ((kind == vsa_pkg::KIND_ON) && (note_velocity == '0));

  assign rd_issue = (state == ST_SCAN) && (idx != CNT_W'(VOICE_SLOTS));
  assign rd_addr  = idx[IDX_W-1:0];

  assign ent   = valid[raddr_q] ? vsa_pkg::slot_entry_t'(rdata) : '0;
  assign match = ent.busy && !ent.rel && (ent.note == note_q);

  assign chosen = have_free ? free_slot : (have_rel ? rel_slot : '0);

  always_comb begin
    we     = 1'b0;
    waddr  = raddr_q;
    wentry = ent;
    if ((state == ST_SCAN) && rv && match && (on_q || !found_off)) begin
      we         = 1'b1;
      wentry.rel = 1'b1;
    end else if ((state == ST_FIN) && on_q) begin
      we     = 1'b1;
      waddr  = chosen;
      wentry = '{busy: 1'b1, rel: 1'b0, note: note_q};
    end
  end

  vsa_ram #(
    .WIDTH(vsa_pkg::ENTRY_W),
    .DEPTH(VOICE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wentry),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      valid  <= '0;
      strobe <= 1'b0;
      rv     <= 1'b0;
    end else begin
      rv     <= rd_issue;
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          strobe <= accept && !(note_on || note_release);
          if (accept) begin
            on_q      <= note_on;
            note_q    <= note_number;
            vel_q     <= note_velocity;
            idx       <= '0;
            have_free <= 1'b0;
            have_rel  <= 1'b0;
            found_off <= 1'b0;
            mask      <= '0;
            if (note_on || note_release) begin
              state <= ST_SCAN;
            end else begin
              if ((kind == vsa_pkg::KIND_DONE) &&
                  (32'(done_slot) < 32'(VOICE_SLOTS))) begin
                valid[done_slot[IDX_W-1:0]] <= 1'b0;
              end
              started        <= 1'b0;
              start_slot     <= '0;
              stolen         <= 1'b0;
              release_mask   <= '0;
              start_note     <= '0;
              start_velocity <= '0;
            end
          end
        end
        ST_SCAN: begin
          strobe <= 1'b0;
          if (rd_issue) begin
            idx <= idx + CNT_W'(1);
          end
          raddr_q <= rd_addr;
          if (rv) begin
            if (match && (on_q || !found_off)) begin
              mask      <= mask | (vsa_pkg::MASK_W'(1) << raddr_q);
              found_off <= 1'b1;
            end
            if (!have_free && !ent.busy) begin
              have_free <= 1'b1;
              free_slot <= raddr_q;
            end
            if (!have_rel && (ent.rel || match)) begin
              have_rel <= 1'b1;
              rel_slot <= raddr_q;
            end
            if (raddr_q == IDX_W'(VOICE_SLOTS - 1)) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          state          <= ST_IDLE;
          strobe         <= 1'b1;
          started        <= on_q;
          start_slot     <= on_q ? vsa_pkg::SLOT_W'(chosen) : '0;
          stolen         <= on_q && !have_free;
          release_mask   <= mask;
          start_note     <= on_q ? note_q : '0;
          start_velocity <= on_q ? vel_q : '0;
        end
        default: begin
          state  <= ST_IDLE;
          strobe <= 1'b0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && !started |-> (start_slot == '0) && !stolen && (start_note == '0) &&
                           (start_velocity == '0))
    else $error("result without a started voice carries slot data");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy) || $past(accept))
    else $error("result strobe without a pending request");

  a_no_rmw_collision: assert property (@(posedge clk) disable iff (rst)
    rd_issue && we |-> rd_addr != waddr)
    else $error("slot read and write collide during scan");

  a_steal_needs_start: assert property (@(posedge clk) disable iff (rst)
    strobe && stolen |-> started)
    else $error("stolen flagged without a started voice");
`endif

endmodule
